/* sv/ax25_pkg.sv */
// ----------------------------------------------------------------------------
// ax25_pkg
// Shared types and codes of the AX.25 UI frame header parser.
// ----------------------------------------------------------------------------
package ax25_pkg;

    localparam int CALL_W = 42;

    localparam logic [1:0] KIND_ADDR = 2'd0;
    localparam logic [1:0] KIND_INFO = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    localparam logic [1:0] ROLE_DEST = 2'd0;
    localparam logic [1:0] ROLE_SRC  = 2'd1;
    localparam logic [1:0] ROLE_DIGI = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_KISS  = 3'd1;
    localparam logic [2:0] ST_SHORT     = 3'd2;
    localparam logic [2:0] ST_NO_CTRL   = 3'd3;
    localparam logic [2:0] ST_NOT_UI    = 3'd4;
    localparam logic [2:0] ST_PATH_LONG = 3'd5;

    // first item of a queue entry: address or info byte
    typedef struct packed {
        logic              valid;
        logic [1:0]        kind;
        logic [1:0]        role;
        logic [CALL_W-1:0] call;
        logic [3:0]        ssid;
        logic              call_ok;
        logic              mark;
        logic [7:0]        info;
    } item_a_t;

    // second item: a digipeater closing the path
    typedef struct packed {
        logic              valid;
        logic [CALL_W-1:0] call;
        logic [3:0]        ssid;
        logic              call_ok;
        logic              mark;
    } item_b_t;

    // third item: frame end status
    typedef struct packed {
        logic       valid;
        logic [2:0] status;
    } item_s_t;

    typedef struct packed {
        item_a_t a;
        item_b_t b;
        item_s_t s;
    } entry_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [1:0]        role;
        logic [CALL_W-1:0] call;
        logic [3:0]        ssid;
        logic              call_ok;
        logic              mark;
        logic [7:0]        info;
        logic [2:0]        status;
        logic              last;
    } out_item_t;

endpackage

/* sv/ax25_front.sv */
// ----------------------------------------------------------------------------
// ax25_front
// Byte parser: tracks frame phase, decodes addresses and builds queue entries
// of up to three result items per accepted byte.
// ----------------------------------------------------------------------------
module ax25_front
    import ax25_pkg::*;
#(
    parameter int MAX_DIGIS = 6
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       raw_mode,
    input  logic       in_valid,
    input  logic [7:0] in_data,
    input  logic       in_last,
    input  logic       in_ready,
    output logic       push,
    output entry_t     push_entry
);

    localparam int CNT_W = $clog2(MAX_DIGIS + 2);

    typedef enum logic [2:0] {
        PH_KISS,
        PH_ADDR,
        PH_CTRL,
        PH_PID,
        PH_INFO,
        PH_DROP
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [2:0]        bia_reg, bia_next;
    logic [CALL_W-1:0] chars_reg, chars_next;
    logic [CALL_W-1:0] pend_call_reg, pend_call_next;
    logic [3:0]        pend_ssid_reg, pend_ssid_next;
    logic              pend_ok_reg, pend_ok_next;
    logic              pend_h_reg, pend_h_next;
    logic              pend_present_reg, pend_present_next;
    logic [2:0]        code_reg, code_next;

    logic              accept;
    logic [3:0]        cur_ssid;
    logic              cur_ok;
    logic              cur_h;
    logic              cur_end;
    logic [7:0]        info_clean;
    logic [2:0]        status;

    function automatic logic call_valid_f(input logic [CALL_W-1:0] call);
        logic [6:0] c;
        logic       ok;
        ok = 1'b1;
        for (int i = 0; i < 6; i++)
        begin
            c = call[7*i +: 7];
            if (!((c >= 7'h41 && c <= 7'h5A) || (c >= 7'h61 && c <= 7'h7A) ||
                  (c >= 7'h30 && c <= 7'h39) || c == 7'h20))
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic logic call_empty_f(input logic [CALL_W-1:0] call,
                                          input logic [3:0] ssid);
        return (ssid == 4'd0) && (call == {6{7'h20}});
    endfunction

    assign accept   = in_valid && in_ready;
    assign cur_ssid = in_data[4:1];
    assign cur_ok   = call_valid_f(chars_reg);
    assign cur_h    = in_data[7];
    assign cur_end  = in_data[0];

    always_comb
    begin
        if (!raw_mode && (in_data < 8'h20 || in_data > 8'h7E))
        begin
            info_clean = 8'h20;
        end
        else
        begin
            info_clean = in_data;
        end
    end

    always_comb
    begin
        phase_next        = phase_reg;
        cnt_next          = cnt_reg;
        bia_next          = bia_reg;
        chars_next        = chars_reg;
        pend_call_next    = pend_call_reg;
        pend_ssid_next    = pend_ssid_reg;
        pend_ok_next      = pend_ok_reg;
        pend_h_next       = pend_h_reg;
        pend_present_next = pend_present_reg;
        code_next         = code_reg;
        push_entry        = '0;
        status            = ST_OK;

        if (accept)
        begin
            case (phase_reg)
                PH_KISS:
                begin
                    if (|in_data[3:0])
                    begin
                        phase_next        = PH_DROP;
                        code_next         = ST_NOT_KISS;
                        pend_present_next = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_ADDR;
                        cnt_next   = '0;
                        bia_next   = 3'd0;
                        chars_next = '0;
                    end
                end
                PH_ADDR:
                begin
                    if (bia_reg < 3'd6)
                    begin
                        chars_next = {chars_reg[CALL_W-8:0], in_data[7:1]};
                        bia_next   = bia_reg + 3'd1;
                    end
                    else
                    begin
                        bia_next   = 3'd0;
                        chars_next = '0;
                        if (cnt_reg == CNT_W'(0))
                        begin
                            push_entry.a.valid   = 1'b1;
                            push_entry.a.kind    = KIND_ADDR;
                            push_entry.a.role    = ROLE_DEST;
                            push_entry.a.call    = chars_reg;
                            push_entry.a.ssid    = cur_ssid;
                            push_entry.a.call_ok = cur_ok;
                            cnt_next             = CNT_W'(1);
                        end
                        else if (cnt_reg == CNT_W'(1))
                        begin
                            push_entry.a.valid   = 1'b1;
                            push_entry.a.kind    = KIND_ADDR;
                            push_entry.a.role    = ROLE_SRC;
                            push_entry.a.call    = chars_reg;
                            push_entry.a.ssid    = cur_ssid;
                            push_entry.a.call_ok = cur_ok;
                            if (cur_end)
                            begin
                                phase_next = PH_CTRL;
                            end
                            else
                            begin
                                cnt_next = CNT_W'(2);
                            end
                        end
                        else
                        begin
                            if (pend_present_reg)
                            begin
                                push_entry.a.valid   = !call_empty_f(pend_call_reg,
                                                                     pend_ssid_reg);
                                push_entry.a.kind    = KIND_ADDR;
                                push_entry.a.role    = ROLE_DIGI;
                                push_entry.a.call    = pend_call_reg;
                                push_entry.a.ssid    = pend_ssid_reg;
                                push_entry.a.call_ok = pend_ok_reg;
                                push_entry.a.mark    = pend_h_reg && !cur_h;
                                pend_present_next    = 1'b0;
                            end
                            if (cur_end)
                            begin
                                push_entry.b.valid   = !call_empty_f(chars_reg, cur_ssid);
                                push_entry.b.call    = chars_reg;
                                push_entry.b.ssid    = cur_ssid;
                                push_entry.b.call_ok = cur_ok;
                                push_entry.b.mark    = cur_h;
                                phase_next           = PH_CTRL;
                            end
                            else if (cnt_reg >= CNT_W'(MAX_DIGIS + 1))
                            begin
                                phase_next        = PH_DROP;
                                code_next         = ST_PATH_LONG;
                                pend_present_next = 1'b0;
                            end
                            else
                            begin
                                pend_call_next    = chars_reg;
                                pend_ssid_next    = cur_ssid;
                                pend_ok_next      = cur_ok;
                                pend_h_next       = cur_h;
                                pend_present_next = 1'b1;
                                cnt_next          = cnt_reg + CNT_W'(1);
                            end
                        end
                    end
                end
                PH_CTRL:
                begin
                    if (in_data != 8'h03)
                    begin
                        phase_next        = PH_DROP;
                        code_next         = ST_NOT_UI;
                        pend_present_next = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_PID;
                    end
                end
                PH_PID:
                begin
                    if (in_data != 8'hF0)
                    begin
                        phase_next        = PH_DROP;
                        code_next         = ST_NOT_UI;
                        pend_present_next = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_INFO;
                    end
                end
                PH_INFO:
                begin
                    push_entry.a.valid = 1'b1;
                    push_entry.a.kind  = KIND_INFO;
                    push_entry.a.info  = info_clean;
                end
                default:
                begin
                end
            endcase

            if (in_last)
            begin
                case (phase_next)
                    PH_DROP: status = code_next;
                    PH_ADDR: status = (cnt_next <= CNT_W'(1)) ? ST_SHORT : ST_NO_CTRL;
                    PH_CTRL: status = ST_NO_CTRL;
                    PH_PID:  status = ST_NO_CTRL;
                    PH_INFO: status = ST_OK;
                    default: status = ST_SHORT;
                endcase
                push_entry.s.valid = 1'b1;
                push_entry.s.status = status;
                phase_next        = PH_KISS;
                cnt_next          = '0;
                bia_next          = 3'd0;
                chars_next        = '0;
                pend_present_next = 1'b0;
                code_next         = ST_OK;
            end
        end
    end

    assign push = accept && (push_entry.a.valid || push_entry.b.valid || push_entry.s.valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_KISS;
            cnt_reg          <= '0;
            bia_reg          <= 3'd0;
            chars_reg        <= '0;
            pend_call_reg    <= '0;
            pend_ssid_reg    <= 4'd0;
            pend_ok_reg      <= 1'b0;
            pend_h_reg       <= 1'b0;
            pend_present_reg <= 1'b0;
            code_reg         <= ST_OK;
        end
        else
        begin
            phase_reg        <= phase_next;
            cnt_reg          <= cnt_next;
            bia_reg          <= bia_next;
            chars_reg        <= chars_next;
            pend_call_reg    <= pend_call_next;
            pend_ssid_reg    <= pend_ssid_next;
            pend_ok_reg      <= pend_ok_next;
            pend_h_reg       <= pend_h_next;
            pend_present_reg <= pend_present_next;
            code_reg         <= code_next;
        end
    end

endmodule

/* sv/ax25_queue.sv */
// ----------------------------------------------------------------------------
// ax25_queue
// Short register queue of parsed entries between the parser and the output
// serializer.
// ----------------------------------------------------------------------------
module ax25_queue
    import ax25_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   not_empty,
    output entry_t head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t            mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

/* sv/ax25_back.sv */
// ----------------------------------------------------------------------------
// ax25_back
// Output serializer: sends the valid items of the head entry one per
// transfer, in order, and releases the entry after its last item.
// ----------------------------------------------------------------------------
module ax25_back
    import ax25_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  entry_t    head,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic done_a_reg, done_a_next;
    logic done_b_reg, done_b_next;
    logic rem_a, rem_b;
    logic xfer;
    logic more;

    assign rem_a     = head.a.valid && !done_a_reg;
    assign rem_b     = head.b.valid && !done_b_reg;
    assign out_valid = head_valid;
    assign xfer      = head_valid && out_ready;

    always_comb
    begin
        out_item = '0;
        if (rem_a)
        begin
            out_item.kind    = head.a.kind;
            out_item.role    = head.a.role;
            out_item.call    = head.a.call;
            out_item.ssid    = head.a.ssid;
            out_item.call_ok = head.a.call_ok;
            out_item.mark    = head.a.mark;
            out_item.info    = head.a.info;
            more             = rem_b || head.s.valid;
        end
        else if (rem_b)
        begin
            out_item.kind    = KIND_ADDR;
            out_item.role    = ROLE_DIGI;
            out_item.call    = head.b.call;
            out_item.ssid    = head.b.ssid;
            out_item.call_ok = head.b.call_ok;
            out_item.mark    = head.b.mark;
            more             = head.s.valid;
        end
        else
        begin
            out_item.kind   = KIND_END;
            out_item.status = head.s.status;
            out_item.last   = 1'b1;
            more            = 1'b0;
        end
    end

    assign pop = xfer && !more;

    always_comb
    begin
        done_a_next = done_a_reg;
        done_b_next = done_b_reg;
        if (pop)
        begin
            done_a_next = 1'b0;
            done_b_next = 1'b0;
        end
        else if (xfer)
        begin
            if (rem_a)
            begin
                done_a_next = 1'b1;
            end
            else
            begin
                done_b_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_a_reg <= 1'b0;
            done_b_reg <= 1'b0;
        end
        else
        begin
            done_a_reg <= done_a_next;
            done_b_reg <= done_b_next;
        end
    end

endmodule

/* sv/ax25_ui_frame_header_parser_unit.sv */
// A result item is written into the entry queue and offered from its head.
// Throughput: one byte per cycle while the queue is not full; the output moves
// one item per cycle while m_axis_tready is high, so a byte causing two or
// three items holds the output once per item; the QUEUE_DEPTH entry queue takes up the difference.
// Reset (rst_n low, asynchronous): parser waits for a KISS type byte, queue
// empty, raw_mode cleared.
// ----------------------------------------------------------------------------
// ax25_ui_frame_header_parser_unit
// KISS / AX.25 UI frame header parser: address, info and status items.
// ----------------------------------------------------------------------------
module ax25_ui_frame_header_parser_unit
    import ax25_pkg::*;
#(
    parameter int MAX_DIGIS   = 6,
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,       // raw_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // role[1:0], callsign[43:2], ssid[47:44], call_valid[48],
    // repeated_mark[49], info_byte[57:50], status[60:58], zero[63:61]
    output logic [63:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // kind[1:0]
    output logic        m_axis_tlast    // last_item
);

    logic      raw_mode_reg;
    logic      push;
    entry_t    push_entry;
    logic      full;
    logic      pop;
    logic      not_empty;
    entry_t    head;
    out_item_t out_item;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_mode_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            raw_mode_reg <= cfg_data;
        end
    end

    ax25_front #(
        .MAX_DIGIS (MAX_DIGIS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .raw_mode   (raw_mode_reg),
        .in_valid   (s_axis_tvalid),
        .in_data    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .in_ready   (s_axis_tready),
        .push       (push),
        .push_entry (push_entry)
    );

    ax25_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .not_empty  (not_empty),
        .head       (head)
    );

    ax25_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (not_empty),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_item   (out_item)
    );

    assign m_axis_tdata = {3'b000, out_item.status, out_item.info, out_item.mark,
                           out_item.call_ok, out_item.ssid, out_item.call, out_item.role};
    assign m_axis_tuser = out_item.kind;
    assign m_axis_tlast = out_item.last;

endmodule
